[sv/ucp_pkg.sv]
// ucp_pkg: shared types, character codes and command texts for the
// motor command parser. No dependencies; imported by every module.
`timescale 1ns / 1ps

package ucp_pkg;

  // Received character codes
  localparam logic [7:0] CHAR_END   = 8'h2E;  // '.' ends a message
  localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-' selects reverse
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // digit offset

  // Command text lengths and digit field position
  localparam int SPEED_LEN = 15;
  localparam int STOP_LEN  = 13;
  localparam int DIGIT_POS = 15;
  localparam int COUNT_W   = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  localparam int TOP_W  = 16;
  localparam int DUTY_W = 12;
  localparam logic [TOP_W-1:0] PWM_TOP_RESET = 16'd50;

  // Result status codes
  typedef enum logic [1:0] {
    ST_SPEED = 2'd0,
    ST_STOP  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // "dc motor speed=" and "dc motor stop"
  localparam logic [7:0] SPEED_TEXT [SPEED_LEN] = '{
    8'h64, 8'h63, 8'h20, 8'h6D, 8'h6F, 8'h74, 8'h6F, 8'h72,
    8'h20, 8'h73, 8'h70, 8'h65, 8'h65, 8'h64, 8'h3D
  };
  localparam logic [7:0] STOP_TEXT [STOP_LEN] = '{
    8'h64, 8'h63, 8'h20, 8'h6D, 8'h6F, 8'h74, 8'h6F, 8'h72,
    8'h20, 8'h73, 8'h74, 8'h6F, 8'h70
  };

  // Running message state, passed from the tracker to the evaluator
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               speed_ok;
    logic               stop_ok;
    logic [2:0][7:0]    digits;  // message bytes 15..17
  } msg_state_t;

endpackage

[sv/ucp_msg_track.sv]
// ucp_msg_track: per-byte message state (position count, prefix match
// flags, captured digit bytes). Depends on ucp_pkg.
`timescale 1ns / 1ps

module ucp_msg_track import ucp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,     // a byte leaves the input stage this cycle
  input  logic [7:0] rx_byte,
  output msg_state_t msg
);

  msg_state_t msg_r, msg_nxt;
  logic       is_end;
  logic [3:0] tidx;

  assign is_end = (rx_byte == CHAR_END);
  assign tidx   = msg_r.count[3:0];

  // Next message state
  always_comb begin
    msg_nxt = msg_r;
    if (step) begin
      if (is_end) begin
        msg_nxt.count    = '0;
        msg_nxt.speed_ok = 1'b1;
        msg_nxt.stop_ok  = 1'b1;
      end else begin
        if (msg_r.count < COUNT_W'(SPEED_LEN) && rx_byte != SPEED_TEXT[tidx])
          msg_nxt.speed_ok = 1'b0;
        if (msg_r.count < COUNT_W'(STOP_LEN) && rx_byte != STOP_TEXT[tidx])
          msg_nxt.stop_ok = 1'b0;
        if (msg_r.count == COUNT_W'(DIGIT_POS))     msg_nxt.digits[0] = rx_byte;
        if (msg_r.count == COUNT_W'(DIGIT_POS + 1)) msg_nxt.digits[1] = rx_byte;
        if (msg_r.count == COUNT_W'(DIGIT_POS + 2)) msg_nxt.digits[2] = rx_byte;
        if (msg_r.count != COUNT_MAX)
          msg_nxt.count = msg_r.count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_r.count    <= '0;
      msg_r.speed_ok <= 1'b1;
      msg_r.stop_ok  <= 1'b1;
      msg_r.digits   <= '0;
    end else begin
      msg_r <= msg_nxt;
    end
  end

  assign msg = msg_r;

endmodule

[sv/ucp_cmd_eval.sv]
// ucp_cmd_eval: decodes a finished message into the motor drive values,
// holds the driven direction/compare and the result register. Depends on ucp_pkg.
`timescale 1ns / 1ps

module ucp_cmd_eval import ucp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,       // a period leaves the input stage
  input  msg_state_t       msg,
  input  logic [TOP_W-1:0] pwm_top,
  output logic             load_ok,    // result register can take a beat
  output logic             out_valid,
  input  logic             out_ready,
  output status_t          status,
  output logic             dir_level,
  output logic [TOP_W-1:0] compare_value,
  output logic [DUTY_W-1:0] duty_value,
  output logic             reverse_flag
);

  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic              dir_r, dir_nxt;
  logic [TOP_W-1:0]  cmp_r, cmp_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  logic              rev_r, rev_nxt;

  logic              rev_sel;
  logic [7:0]        tens, ones;
  logic [DUTY_W-1:0] duty_raw;
  logic [TOP_W-1:0]  duty_ext, duty_clamp;
  logic              is_speed, is_stop;

  // Digit decode: sign in byte 15 shifts the digits by one
  assign rev_sel  = (msg.digits[0] == CHAR_MINUS);
  assign tens     = (rev_sel ? msg.digits[1] : msg.digits[0]) - CHAR_ZERO;
  assign ones     = (rev_sel ? msg.digits[2] : msg.digits[1]) - CHAR_ZERO;
  assign duty_raw = ({4'd0, tens} << 3) + ({4'd0, tens} << 1) + {4'd0, ones};
  assign duty_ext = {{(TOP_W-DUTY_W){1'b0}}, duty_raw};
  assign duty_clamp = (duty_ext > pwm_top) ? pwm_top : duty_ext;

  assign is_speed = (msg.count >= COUNT_W'(SPEED_LEN)) && msg.speed_ok;
  assign is_stop  = (msg.count >= COUNT_W'(STOP_LEN)) && msg.stop_ok;

  // Command decode
  always_comb begin
    status_nxt = ST_ERROR;
    dir_nxt    = dir_r;
    cmp_nxt    = cmp_r;
    duty_nxt   = '0;
    rev_nxt    = 1'b0;
    if (is_speed) begin
      status_nxt = ST_SPEED;
      duty_nxt   = duty_raw;
      rev_nxt    = rev_sel;
      dir_nxt    = rev_sel;
      cmp_nxt    = rev_sel ? (pwm_top - duty_clamp) : duty_clamp;
    end else if (is_stop) begin
      status_nxt = ST_STOP;
      dir_nxt    = 1'b0;
      cmp_nxt    = '0;
    end
  end

  assign load_ok = !out_valid_r || out_ready;

  // Drive state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      dir_r       <= 1'b0;
      cmp_r       <= '0;
      status_r    <= ST_ERROR;
      duty_r      <= '0;
      rev_r       <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        status_r    <= status_nxt;
        dir_r       <= dir_nxt;
        cmp_r       <= cmp_nxt;
        duty_r      <= duty_nxt;
        rev_r       <= rev_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign status        = status_r;
  assign dir_level     = dir_r;
  assign compare_value = cmp_r;
  assign duty_value    = duty_r;
  assign reverse_flag  = rev_r;

endmodule

[sv/uart_motor_command_parser.sv]
// uart_motor_command_parser: top level; input byte stage, PWM top register,
// message tracker and command evaluator. Depends on ucp_pkg, ucp_msg_track, ucp_cmd_eval.
//
//   channel | dir | beat payload
//   --------+-----+-----------------------------------------------------
//   in_     | in  | rx_byte[7:0]
//   out_    | out | status, dir_level, compare_value, duty_value, reverse_flag
//   cfg_    | in  | pwm_top[15:0]
//
// One byte per cycle unless a period waits in the input register for a stalled
// out_ side; a period beat lands in the input register when accepted and its
// result is then loaded into the result register, which raises out_tvalid.
// Reset clears the message state, drive state and sets pwm_top to 50.
// A stalled out_ side holds only period beats; other bytes keep flowing
// until a period reaches the input register while a result still waits.
`timescale 1ns / 1ps

module uart_motor_command_parser import ucp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // rx_byte[7:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // status[1:0], dir_level[2], compare_value[18:3], duty_value[30:19],
  // reverse_flag[31]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // pwm_top[15:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic             in_vld_r;
  logic [7:0]       in_byte_r;
  logic [TOP_W-1:0] pwm_top_r;
  logic             s1_end, s1_adv, load_ok;
  msg_state_t       msg;
  status_t          status;
  logic             dir_level, reverse_flag;
  logic [TOP_W-1:0] compare_value;
  logic [DUTY_W-1:0] duty_value;

  // Input stage handshake
  assign s1_end    = (in_byte_r == CHAR_END);
  assign s1_adv    = in_vld_r && (!s1_end || load_ok);
  assign in_tready = !in_vld_r || s1_adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      pwm_top_r <= PWM_TOP_RESET;
    end else begin
      if (in_tready)
        in_vld_r <= in_tvalid;
      if (cfg_valid)
        pwm_top_r <= cfg_data;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid)
      in_byte_r <= in_tdata;
  end

  ucp_msg_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .rx_byte (in_byte_r),
    .msg     (msg)
  );

  ucp_cmd_eval u_eval (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (s1_adv && s1_end),
    .msg           (msg),
    .pwm_top       (pwm_top_r),
    .load_ok       (load_ok),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .status        (status),
    .dir_level     (dir_level),
    .compare_value (compare_value),
    .duty_value    (duty_value),
    .reverse_flag  (reverse_flag)
  );

  assign out_tdata = {reverse_flag, duty_value, compare_value, dir_level, status};

endmodule
